// ----- src/svi_pkg.sv -----
// Shared types, constants and fixed-point helpers of the SVI smile evaluator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package svi_pkg;

	localparam int FRAC_BITS   = 24;
	localparam int WORD_BITS   = 32;
	localparam int INT_BITS    = 64;
	localparam int RHO_BITS    = FRAC_BITS + 2;
	localparam int IDX_BITS    = 3;

	localparam int MUL_LAT     = 3;
	localparam int DIV_STEPS   = INT_BITS;
	localparam int DIV_LAT     = DIV_STEPS + 2;
	localparam int SQRT_DIGITS = (INT_BITS + FRAC_BITS) / 2;
	localparam int SQRT_LAT    = SQRT_DIGITS + 1;
	localparam int RAD_BITS    = 2 * SQRT_DIGITS;
	localparam int SREM_BITS   = SQRT_DIGITS + 4;
	localparam int PIPE_LAT    = 2 + 6 * MUL_LAT + 2 * SQRT_LAT + 2 * DIV_LAT;

	typedef logic signed [INT_BITS-1:0] val_t;
	typedef logic [INT_BITS-1:0] umag_t;

	localparam val_t VAL_MAX   = {1'b0, {(INT_BITS-1){1'b1}}};
	localparam val_t VAL_MIN   = {1'b1, {(INT_BITS-1){1'b0}}};
	localparam val_t ONE_Q     = val_t'(1) <<< FRAC_BITS;
	localparam val_t HALF_Q    = val_t'(1) <<< (FRAC_BITS - 1);
	localparam val_t QUARTER_Q = val_t'(1) <<< (FRAC_BITS - 2);
	localparam val_t OUT_MAX   = (val_t'(1) <<< (WORD_BITS - 1)) - val_t'(1);
	localparam val_t OUT_MIN   = -OUT_MAX - val_t'(1);

	localparam logic [IDX_BITS-1:0] REG_LEVEL_A         = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_SLOPE_B         = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_SKEW_RHO        = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_SHIFT_M         = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_CURVATURE_SIGMA = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_MATURITY_YEARS  = 3'd5;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NONPOS = 2'd1,
		STAT_SAT    = 2'd2
	} status_t;

	typedef struct packed {
		val_t v;
		logic sat;
	} res_t;

	typedef struct packed {
		logic zero_den;
		logic num_zero;
		logic num_neg;
		logic neg;
		logic ovf;
	} div_ctl_t;

	typedef struct packed {
		umag_t rem;
		logic  q;
	} dstep_t;

	typedef struct packed {
		logic [SREM_BITS-1:0]   rem;
		logic [SQRT_DIGITS-1:0] root;
	} sstep_t;

	typedef struct packed {
		val_t                  x;
		val_t                  d;
		val_t                  ss;
		val_t                  q;
		val_t                  rd;
		val_t                  r;
		val_t                  w;
		logic signed [WORD_BITS-1:0] tv;
		logic signed [WORD_BITS-1:0] iv;
		val_t                  t;
		val_t                  bsq;
		val_t                  dw2;
		val_t                  d2;
		logic signed [WORD_BITS-1:0] g;
		logic                  sat;
	} ctx_t;

	function automatic umag_t mag(input val_t v);
		mag = v[INT_BITS-1] ? umag_t'(-v) : umag_t'(v);
	endfunction

	function automatic res_t from_mag(input umag_t m, input logic neg, input logic ovf);
		res_t r;
		if (neg) begin
			if (ovf || m > umag_t'(VAL_MIN)) begin
				r.v = VAL_MIN;
				r.sat = 1'b1;
			end else begin
				r.v = val_t'(-m);
				r.sat = 1'b0;
			end
		end else begin
			if (ovf || m[INT_BITS-1]) begin
				r.v = VAL_MAX;
				r.sat = 1'b1;
			end else begin
				r.v = val_t'(m);
				r.sat = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic res_t sadd(input val_t a, input val_t b);
		logic signed [INT_BITS:0] s;
		res_t r;
		s = {a[INT_BITS-1], a} + {b[INT_BITS-1], b};
		r.sat = s[INT_BITS] != s[INT_BITS-1];
		r.v = r.sat ? (s[INT_BITS] ? VAL_MIN : VAL_MAX) : s[INT_BITS-1:0];
		return r;
	endfunction

	function automatic res_t ssub(input val_t a, input val_t b);
		logic signed [INT_BITS:0] s;
		res_t r;
		s = {a[INT_BITS-1], a} - {b[INT_BITS-1], b};
		r.sat = s[INT_BITS] != s[INT_BITS-1];
		r.v = r.sat ? (s[INT_BITS] ? VAL_MIN : VAL_MAX) : s[INT_BITS-1:0];
		return r;
	endfunction

	function automatic res_t clamp_w(input val_t a);
		res_t r;
		r.sat = (a > OUT_MAX) || (a < OUT_MIN);
		r.v = (a > OUT_MAX) ? OUT_MAX : ((a < OUT_MIN) ? OUT_MIN : a);
		return r;
	endfunction

	function automatic dstep_t div_step(input umag_t rem, input logic nbit, input umag_t d);
		logic [INT_BITS:0] t;
		dstep_t r;
		t = {rem, nbit};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
			r.q = 1'b1;
		end else begin
			r.q = 1'b0;
		end
		r.rem = t[INT_BITS-1:0];
		return r;
	endfunction

	function automatic sstep_t sqrt_step(input logic [SREM_BITS-1:0] rem,
			input logic [SQRT_DIGITS-1:0] root, input logic [1:0] pair);
		logic [SREM_BITS-1:0] t;
		logic [SREM_BITS-1:0] trial;
		sstep_t r;
		t = {rem[SREM_BITS-3:0], pair};
		trial = {2'b00, root, 2'b01};
		if (t >= trial) begin
			r.rem = t - trial;
			r.root = {root[SQRT_DIGITS-2:0], 1'b1};
		end else begin
			r.rem = t;
			r.root = {root[SQRT_DIGITS-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/svi_fmul.sv -----
// Saturating signed fixed-point multiplier, three register stages.
// Splits the magnitudes into 32-bit partial products; uses svi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svi_fmul (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid_i,
	input  wire svi_pkg::val_t a_i,
	input  wire svi_pkg::val_t b_i,
	input  wire svi_pkg::ctx_t side_i,
	output logic               valid_o,
	output svi_pkg::res_t      res_o,
	output svi_pkg::ctx_t      side_o
);

	logic                  vld_s1, vld_s2, vld_s3;
	svi_pkg::umag_t        ma_s1, mb_s1;
	logic                  neg_s1, neg_s2;
	svi_pkg::ctx_t         side_s1, side_s2, side_s3;
	logic [63:0]           pp00_s2, pp01_s2, pp10_s2, pp11_s2;
	svi_pkg::res_t         res_s3;
	logic [127:0]          prod;
	logic [127:0]          shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= valid_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		prod = {64'd0, pp00_s2} + ({64'd0, pp01_s2} << 32) + ({64'd0, pp10_s2} << 32)
			+ {pp11_s2, 64'd0};
		shifted = prod >> svi_pkg::FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		ma_s1   <= svi_pkg::mag(a_i);
		mb_s1   <= svi_pkg::mag(b_i);
		neg_s1  <= a_i[63] ^ b_i[63];
		side_s1 <= side_i;
		pp00_s2 <= ma_s1[31:0] * mb_s1[31:0];
		pp01_s2 <= ma_s1[31:0] * mb_s1[63:32];
		pp10_s2 <= ma_s1[63:32] * mb_s1[31:0];
		pp11_s2 <= ma_s1[63:32] * mb_s1[63:32];
		neg_s2  <= neg_s1;
		side_s2 <= side_s1;
		res_s3  <= svi_pkg::from_mag(shifted[63:0], neg_s2, |shifted[127:64]);
		side_s3 <= side_s2;
	end

	assign valid_o = vld_s3;
	assign res_o   = res_s3;
	assign side_o  = side_s3;

endmodule

`default_nettype wire

// ----- src/svi_fdiv.sv -----
// Saturating signed fixed-point divider, one quotient bit per pipeline stage.
// Computes (num << FRAC_BITS) / den truncated toward zero; uses svi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svi_fdiv (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid_i,
	input  wire svi_pkg::val_t num_i,
	input  wire svi_pkg::val_t den_i,
	input  wire svi_pkg::ctx_t side_i,
	output logic               valid_o,
	output svi_pkg::res_t      res_o,
	output svi_pkg::ctx_t      side_o
);

	localparam int N = svi_pkg::DIV_STEPS;

	logic               vld_s  [0:N];
	svi_pkg::umag_t     rem_s  [0:N];
	svi_pkg::umag_t     lo_s   [0:N];
	svi_pkg::umag_t     quo_s  [0:N];
	svi_pkg::umag_t     den_s  [0:N];
	svi_pkg::div_ctl_t  ctl_s  [0:N];
	svi_pkg::ctx_t      side_s [0:N];
	svi_pkg::dstep_t    step   [0:N-1];
	logic               vld_q;
	svi_pkg::res_t      res_q;
	svi_pkg::ctx_t      side_q;
	svi_pkg::umag_t     ma;
	svi_pkg::umag_t     md;
	svi_pkg::div_ctl_t  ctl_in;
	svi_pkg::res_t      fin;

	always_comb begin
		ma = svi_pkg::mag(num_i);
		md = svi_pkg::mag(den_i);
		ctl_in.zero_den = den_i == '0;
		ctl_in.num_zero = num_i == '0;
		ctl_in.num_neg  = num_i[63];
		ctl_in.neg      = num_i[63] ^ den_i[63];
		ctl_in.ovf      = (ma >> (svi_pkg::INT_BITS - svi_pkg::FRAC_BITS)) >= md;
	end

	always_comb begin
		for (int k = 0; k < N; k++) begin
			step[k] = svi_pkg::div_step(rem_s[k], lo_s[k][63], den_s[k]);
		end
	end

	always_comb begin
		if (ctl_s[N].zero_den) begin
			fin.sat = 1'b1;
			if (ctl_s[N].num_zero) begin
				fin.v = '0;
			end else begin
				fin.v = ctl_s[N].num_neg ? svi_pkg::VAL_MIN : svi_pkg::VAL_MAX;
			end
		end else if (ctl_s[N].ovf) begin
			fin = svi_pkg::from_mag('0, ctl_s[N].neg, 1'b1);
		end else begin
			fin = svi_pkg::from_mag(quo_s[N], ctl_s[N].neg, 1'b0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= N; k++) begin
				vld_s[k] <= 1'b0;
			end
			vld_q <= 1'b0;
		end else begin
			vld_s[0] <= valid_i;
			for (int k = 0; k < N; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
			vld_q <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= ma >> (svi_pkg::INT_BITS - svi_pkg::FRAC_BITS);
		lo_s[0]   <= ma << svi_pkg::FRAC_BITS;
		quo_s[0]  <= '0;
		den_s[0]  <= md;
		ctl_s[0]  <= ctl_in;
		side_s[0] <= side_i;
		for (int k = 0; k < N; k++) begin
			rem_s[k+1]  <= step[k].rem;
			lo_s[k+1]   <= lo_s[k] << 1;
			quo_s[k+1]  <= {quo_s[k][62:0], step[k].q};
			den_s[k+1]  <= den_s[k];
			ctl_s[k+1]  <= ctl_s[k];
			side_s[k+1] <= side_s[k];
		end
		res_q  <= fin;
		side_q <= side_s[N];
	end

	assign valid_o = vld_q;
	assign res_o   = res_q;
	assign side_o  = side_q;

endmodule

`default_nettype wire

// ----- src/svi_fsqrt.sv -----
// Pipelined fixed-point square root, one root bit per stage.
// Gives floor(sqrt(v << FRAC_BITS)) and zero for v <= 0; uses svi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svi_fsqrt (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid_i,
	input  wire svi_pkg::val_t val_i,
	input  wire svi_pkg::ctx_t side_i,
	output logic               valid_o,
	output svi_pkg::val_t      root_o,
	output svi_pkg::ctx_t      side_o
);

	localparam int N = svi_pkg::SQRT_DIGITS;

	logic                              vld_s  [0:N];
	logic [svi_pkg::RAD_BITS-1:0]      rad_s  [0:N];
	logic [svi_pkg::SREM_BITS-1:0]     rem_s  [0:N];
	logic [N-1:0]                      root_s [0:N];
	svi_pkg::ctx_t                     side_s [0:N];
	svi_pkg::sstep_t                   step   [0:N-1];
	logic [svi_pkg::RAD_BITS-1:0]      rad_in;

	always_comb begin
		if (val_i > svi_pkg::val_t'(0)) begin
			rad_in = svi_pkg::RAD_BITS'(val_i) << svi_pkg::FRAC_BITS;
		end else begin
			rad_in = '0;
		end
	end

	always_comb begin
		for (int k = 0; k < N; k++) begin
			step[k] = svi_pkg::sqrt_step(rem_s[k], root_s[k],
				rad_s[k][svi_pkg::RAD_BITS-1 -: 2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= N; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[0] <= valid_i;
			for (int k = 0; k < N; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		rad_s[0]  <= rad_in;
		rem_s[0]  <= '0;
		root_s[0] <= '0;
		side_s[0] <= side_i;
		for (int k = 0; k < N; k++) begin
			rad_s[k+1]  <= rad_s[k] << 2;
			rem_s[k+1]  <= step[k].rem;
			root_s[k+1] <= step[k].root;
			side_s[k+1] <= side_s[k];
		end
	end

	assign valid_o = vld_s[N];
	assign root_o  = svi_pkg::val_t'(root_s[N]);
	assign side_o  = side_s[N];

endmodule

`default_nettype wire

// ----- src/svi_smile_evaluator_core.sv -----
// Top level of the raw SVI smile evaluator: configuration registers and the datapath.
// Chains svi_fmul, svi_fdiv and svi_fsqrt stages; uses svi_pkg.
//
//   channel   ports                                               direction
//   config    cfg_we, cfg_index, cfg_data                         in
//   item in   start, busy, log_moneyness                          in (busy out)
//   result    done, total_var, implied_var, implied_vol,
//             density_factor, status                              out
//
// One item enters per cycle; each result passes from its start through the input
// register, six multiplier phases, two square root pipelines and two divider
// pipelines in series, then the output register. Busy stays low, the pipeline
// never stalls, and the receiver must take done when it shows. Reset clears the
// valid bits and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module svi_smile_evaluator_core (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [svi_pkg::IDX_BITS-1:0]           cfg_index,
	input  wire logic [svi_pkg::WORD_BITS-1:0]          cfg_data,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic signed [svi_pkg::WORD_BITS-1:0]   log_moneyness,
	output logic                                        done,
	output logic signed [svi_pkg::WORD_BITS-1:0]        total_var,
	output logic signed [svi_pkg::WORD_BITS-1:0]        implied_var,
	output logic [svi_pkg::WORD_BITS-2:0]               implied_vol,
	output logic signed [svi_pkg::WORD_BITS-1:0]        density_factor,
	output logic [1:0]                                  status
);

	logic signed [svi_pkg::WORD_BITS-1:0] level_a_q;
	logic [svi_pkg::WORD_BITS-2:0]        slope_b_q;
	logic signed [svi_pkg::RHO_BITS-1:0]  skew_rho_q;
	logic signed [svi_pkg::WORD_BITS-1:0] shift_m_q;
	logic [svi_pkg::WORD_BITS-2:0]        curvature_sigma_q;
	logic [svi_pkg::WORD_BITS-2:0]        maturity_years_q;

	svi_pkg::val_t a64, b64, rho64, sig64, mat64;

	logic          vld_s1;
	svi_pkg::ctx_t ctx_in;
	svi_pkg::ctx_t ctx_s1;

	logic p1_vld, p2_vld, p3_vld, p4_vld, p5_vld, p6_vld, p7_vld, p8_vld, p9_vld, p10_vld;
	svi_pkg::ctx_t p1_ctx, p2_ctx, p3_ctx, p4_ctx, p5_ctx, p6_ctx, p7_ctx, p8_ctx;
	svi_pkg::ctx_t p9_ctx, p10_ctx;
	svi_pkg::ctx_t b1_ctx, b2_ctx, b3_ctx, b4_ctx, b5_ctx, b6_ctx, b7_ctx, b8_ctx, b9_ctx;
	svi_pkg::res_t p1_dd, p1_ss, p1_rd, p3_bw, p4_iv, p4_dr, p4_sq, p4_inv;
	svi_pkg::res_t p5_dw, p5_bsq, p6_xdw, p6_dw2, p7_k, p7_d2, p8_kh, p8_p;
	svi_pkg::res_t p9_hh, p9_qp, p9_hd2;
	svi_pkg::val_t p2_r, p10_vol;
	svi_pkg::res_t b1_q, b2_s1, b3_w, b3_tv, b4_iv, b4_t, b4_s2, b8_h, b9_u, b9_g, b9_gc;

	logic                                 done_q;
	logic signed [svi_pkg::WORD_BITS-1:0] tv_q, iv_q, g_q;
	logic [svi_pkg::WORD_BITS-2:0]        vol_q;
	svi_pkg::status_t                     status_q;
	logic                                 invalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_a_q         <= '0;
			slope_b_q         <= '0;
			skew_rho_q        <= '0;
			shift_m_q         <= '0;
			curvature_sigma_q <= (svi_pkg::WORD_BITS-1)'(svi_pkg::ONE_Q);
			maturity_years_q  <= (svi_pkg::WORD_BITS-1)'(svi_pkg::ONE_Q);
		end else if (cfg_we) begin
			unique case (cfg_index)
				svi_pkg::REG_LEVEL_A:         level_a_q <= cfg_data;
				svi_pkg::REG_SLOPE_B:         slope_b_q <= cfg_data[svi_pkg::WORD_BITS-2:0];
				svi_pkg::REG_SKEW_RHO:        skew_rho_q <= cfg_data[svi_pkg::RHO_BITS-1:0];
				svi_pkg::REG_SHIFT_M:         shift_m_q <= cfg_data;
				svi_pkg::REG_CURVATURE_SIGMA: begin
					curvature_sigma_q <= cfg_data[svi_pkg::WORD_BITS-2:0];
				end
				svi_pkg::REG_MATURITY_YEARS:  begin
					maturity_years_q <= cfg_data[svi_pkg::WORD_BITS-2:0];
				end
				default: ;
			endcase
		end
	end

	assign a64   = svi_pkg::val_t'(level_a_q);
	assign b64   = svi_pkg::val_t'(slope_b_q);
	assign rho64 = svi_pkg::val_t'(skew_rho_q);
	assign sig64 = svi_pkg::val_t'(curvature_sigma_q);
	assign mat64 = svi_pkg::val_t'(maturity_years_q);
	assign busy  = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_comb begin
		ctx_in   = '0;
		ctx_in.x = svi_pkg::val_t'(log_moneyness);
		ctx_in.d = svi_pkg::val_t'(log_moneyness) - svi_pkg::val_t'(shift_m_q);
	end

	always_ff @(posedge clk) begin
		ctx_s1 <= ctx_in;
	end

	svi_fmul u_p1_dd (.clk, .arst_n, .valid_i(vld_s1), .a_i(ctx_s1.d), .b_i(ctx_s1.d),
		.side_i(ctx_s1), .valid_o(p1_vld), .res_o(p1_dd), .side_o(p1_ctx));
	svi_fmul u_p1_ss (.clk, .arst_n, .valid_i(vld_s1), .a_i(sig64), .b_i(sig64),
		.side_i('0), .valid_o(), .res_o(p1_ss), .side_o());
	svi_fmul u_p1_rd (.clk, .arst_n, .valid_i(vld_s1), .a_i(rho64), .b_i(ctx_s1.d),
		.side_i('0), .valid_o(), .res_o(p1_rd), .side_o());

	always_comb begin
		b1_q = svi_pkg::sadd(p1_dd.v, p1_ss.v);
		b1_ctx = p1_ctx;
		b1_ctx.ss = p1_ss.v;
		b1_ctx.q = b1_q.v;
		b1_ctx.rd = p1_rd.v;
		b1_ctx.sat = p1_ctx.sat | p1_dd.sat | p1_ss.sat | p1_rd.sat | b1_q.sat;
	end

	svi_fsqrt u_p2_r (.clk, .arst_n, .valid_i(p1_vld), .val_i(b1_ctx.q), .side_i(b1_ctx),
		.valid_o(p2_vld), .root_o(p2_r), .side_o(p2_ctx));

	always_comb begin
		b2_s1 = svi_pkg::sadd(p2_ctx.rd, p2_r);
		b2_ctx = p2_ctx;
		b2_ctx.r = p2_r;
		b2_ctx.sat = p2_ctx.sat | b2_s1.sat;
	end

	svi_fmul u_p3_bw (.clk, .arst_n, .valid_i(p2_vld), .a_i(b64), .b_i(b2_s1.v),
		.side_i(b2_ctx), .valid_o(p3_vld), .res_o(p3_bw), .side_o(p3_ctx));

	always_comb begin
		b3_w = svi_pkg::sadd(a64, p3_bw.v);
		b3_tv = svi_pkg::clamp_w(b3_w.v);
		b3_ctx = p3_ctx;
		b3_ctx.w = b3_w.v;
		b3_ctx.tv = b3_tv.v[svi_pkg::WORD_BITS-1:0];
		b3_ctx.sat = p3_ctx.sat | p3_bw.sat | b3_w.sat | b3_tv.sat;
	end

	svi_fdiv u_p4_iv (.clk, .arst_n, .valid_i(p3_vld), .num_i(b3_ctx.w), .den_i(mat64),
		.side_i(b3_ctx), .valid_o(p4_vld), .res_o(p4_iv), .side_o(p4_ctx));
	svi_fdiv u_p4_dr (.clk, .arst_n, .valid_i(p3_vld), .num_i(b3_ctx.d), .den_i(b3_ctx.r),
		.side_i('0), .valid_o(), .res_o(p4_dr), .side_o());
	svi_fdiv u_p4_sq (.clk, .arst_n, .valid_i(p3_vld), .num_i(b3_ctx.ss), .den_i(b3_ctx.q),
		.side_i('0), .valid_o(), .res_o(p4_sq), .side_o());
	svi_fdiv u_p4_inv (.clk, .arst_n, .valid_i(p3_vld), .num_i(svi_pkg::ONE_Q),
		.den_i(b3_ctx.w), .side_i('0), .valid_o(), .res_o(p4_inv), .side_o());

	always_comb begin
		b4_iv = svi_pkg::clamp_w(p4_iv.v);
		b4_t = svi_pkg::sadd(svi_pkg::QUARTER_Q, p4_inv.v);
		b4_s2 = svi_pkg::sadd(rho64, p4_dr.v);
		b4_ctx = p4_ctx;
		b4_ctx.iv = b4_iv.v[svi_pkg::WORD_BITS-1:0];
		b4_ctx.t = b4_t.v;
		b4_ctx.sat = p4_ctx.sat | p4_iv.sat | b4_iv.sat | p4_inv.sat | b4_t.sat
			| p4_dr.sat | b4_s2.sat | p4_sq.sat;
	end

	svi_fmul u_p5_dw (.clk, .arst_n, .valid_i(p4_vld), .a_i(b64), .b_i(b4_s2.v),
		.side_i(b4_ctx), .valid_o(p5_vld), .res_o(p5_dw), .side_o(p5_ctx));
	svi_fmul u_p5_bsq (.clk, .arst_n, .valid_i(p4_vld), .a_i(b64), .b_i(p4_sq.v),
		.side_i('0), .valid_o(), .res_o(p5_bsq), .side_o());

	always_comb begin
		b5_ctx = p5_ctx;
		b5_ctx.bsq = p5_bsq.v;
		b5_ctx.sat = p5_ctx.sat | p5_dw.sat | p5_bsq.sat;
	end

	svi_fmul u_p6_xdw (.clk, .arst_n, .valid_i(p5_vld), .a_i(b5_ctx.x), .b_i(p5_dw.v),
		.side_i(b5_ctx), .valid_o(p6_vld), .res_o(p6_xdw), .side_o(p6_ctx));
	svi_fmul u_p6_dw2 (.clk, .arst_n, .valid_i(p5_vld), .a_i(p5_dw.v), .b_i(p5_dw.v),
		.side_i('0), .valid_o(), .res_o(p6_dw2), .side_o());

	always_comb begin
		b6_ctx = p6_ctx;
		b6_ctx.dw2 = p6_dw2.v;
		b6_ctx.sat = p6_ctx.sat | p6_xdw.sat | p6_dw2.sat;
	end

	svi_fdiv u_p7_k (.clk, .arst_n, .valid_i(p6_vld), .num_i(p6_xdw.v), .den_i(b6_ctx.w),
		.side_i(b6_ctx), .valid_o(p7_vld), .res_o(p7_k), .side_o(p7_ctx));
	svi_fdiv u_p7_d2 (.clk, .arst_n, .valid_i(p6_vld), .num_i(b6_ctx.bsq), .den_i(b6_ctx.r),
		.side_i('0), .valid_o(), .res_o(p7_d2), .side_o());

	always_comb begin
		b7_ctx = p7_ctx;
		b7_ctx.d2 = p7_d2.v;
		b7_ctx.sat = p7_ctx.sat | p7_k.sat | p7_d2.sat;
	end

	svi_fmul u_p8_kh (.clk, .arst_n, .valid_i(p7_vld), .a_i(p7_k.v), .b_i(svi_pkg::HALF_Q),
		.side_i(b7_ctx), .valid_o(p8_vld), .res_o(p8_kh), .side_o(p8_ctx));
	svi_fmul u_p8_p (.clk, .arst_n, .valid_i(p7_vld), .a_i(b7_ctx.dw2), .b_i(b7_ctx.t),
		.side_i('0), .valid_o(), .res_o(p8_p), .side_o());

	always_comb begin
		b8_h = svi_pkg::ssub(svi_pkg::ONE_Q, p8_kh.v);
		b8_ctx = p8_ctx;
		b8_ctx.sat = p8_ctx.sat | p8_kh.sat | p8_p.sat | b8_h.sat;
	end

	svi_fmul u_p9_hh (.clk, .arst_n, .valid_i(p8_vld), .a_i(b8_h.v), .b_i(b8_h.v),
		.side_i(b8_ctx), .valid_o(p9_vld), .res_o(p9_hh), .side_o(p9_ctx));
	svi_fmul u_p9_qp (.clk, .arst_n, .valid_i(p8_vld), .a_i(svi_pkg::QUARTER_Q),
		.b_i(p8_p.v), .side_i('0), .valid_o(), .res_o(p9_qp), .side_o());
	svi_fmul u_p9_hd2 (.clk, .arst_n, .valid_i(p8_vld), .a_i(svi_pkg::HALF_Q),
		.b_i(b8_ctx.d2), .side_i('0), .valid_o(), .res_o(p9_hd2), .side_o());

	always_comb begin
		b9_u = svi_pkg::ssub(p9_hh.v, p9_qp.v);
		b9_g = svi_pkg::sadd(b9_u.v, p9_hd2.v);
		b9_gc = svi_pkg::clamp_w(b9_g.v);
		b9_ctx = p9_ctx;
		b9_ctx.g = b9_gc.v[svi_pkg::WORD_BITS-1:0];
		b9_ctx.sat = p9_ctx.sat | p9_hh.sat | p9_qp.sat | p9_hd2.sat | b9_u.sat
			| b9_g.sat | b9_gc.sat;
	end

	svi_fsqrt u_p10_vol (.clk, .arst_n, .valid_i(p9_vld), .val_i(svi_pkg::val_t'(b9_ctx.iv)),
		.side_i(b9_ctx), .valid_o(p10_vld), .root_o(p10_vol), .side_o(p10_ctx));

	assign invalid = p10_ctx.w <= svi_pkg::val_t'(0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= p10_vld;
		end
	end

	always_ff @(posedge clk) begin
		tv_q <= p10_ctx.tv;
		iv_q <= p10_ctx.iv;
		vol_q <= invalid ? '0 : p10_vol[svi_pkg::WORD_BITS-2:0];
		g_q <= invalid ? '0 : p10_ctx.g;
		if (invalid) begin
			status_q <= svi_pkg::STAT_NONPOS;
		end else if (p10_ctx.sat) begin
			status_q <= svi_pkg::STAT_SAT;
		end else begin
			status_q <= svi_pkg::STAT_OK;
		end
	end

	assign done           = done_q;
	assign total_var      = tv_q;
	assign implied_var    = iv_q;
	assign implied_vol    = vol_q;
	assign density_factor = g_q;
	assign status         = status_q;

endmodule

`default_nettype wire

// ----- src/svi_checker.sv -----
// Port-level checks on the SVI smile evaluator, bound to the top level.
// Uses svi_pkg for the pipeline latency and status codes.
`timescale 1ns / 1ps
`default_nettype none

module svi_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  cfg_we,
	input wire logic [svi_pkg::IDX_BITS-1:0]          cfg_index,
	input wire logic [svi_pkg::WORD_BITS-1:0]         cfg_data,
	input wire logic                                  start,
	input wire logic                                  busy,
	input wire logic signed [svi_pkg::WORD_BITS-1:0]  log_moneyness,
	input wire logic                                  done,
	input wire logic signed [svi_pkg::WORD_BITS-1:0]  total_var,
	input wire logic signed [svi_pkg::WORD_BITS-1:0]  implied_var,
	input wire logic [svi_pkg::WORD_BITS-2:0]         implied_vol,
	input wire logic signed [svi_pkg::WORD_BITS-1:0]  density_factor,
	input wire logic [1:0]                            status
);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(svi_pkg::PIPE_LAT) done)
		else $error("item result missing at the fixed latency");

	a_nonpos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == svi_pkg::STAT_NONPOS) |-> (implied_vol == '0 && density_factor == '0))
		else $error("non-positive variance with nonzero volatility or density");

	a_ok_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == svi_pkg::STAT_OK) |-> (total_var > 0))
		else $error("clean status with non-positive total variance");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == svi_pkg::STAT_OK || status == svi_pkg::STAT_NONPOS
			|| status == svi_pkg::STAT_SAT))
		else $error("undefined status code");

endmodule

bind svi_smile_evaluator_core svi_checker u_svi_checker (.*);

`default_nettype wire

// ----- bench/svi_smile_evaluator_core_tb.sv -----
// Self-checking bench for svi_smile_evaluator_core: drives log-moneyness items,
// predicts every result of the SVI smile in Q8.24 and compares it field by field.
// Depends on svi_pkg and the RTL of the evaluator only.
`timescale 1ns / 1ps

module svi_smile_evaluator_core_tb;

	typedef logic signed [63:0] wide_t;

	typedef struct {
		logic signed [31:0] tv;
		logic signed [31:0] iv;
		logic [30:0]        vol;
		logic signed [31:0] g;
		svi_pkg::status_t   st;
	} smile_pt_t;

	localparam wide_t W_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam wide_t W_MIN = 64'sh8000_0000_0000_0000;
	localparam wide_t Q_ONE = 64'sd1 <<< 24;
	localparam wide_t Q_HALF = 64'sd1 <<< 23;
	localparam wide_t Q_QUARTER = 64'sd1 <<< 22;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [svi_pkg::IDX_BITS-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic start = 1'b0;
	logic signed [31:0] log_moneyness = '0;
	logic busy, done;
	logic signed [31:0] total_var, implied_var, density_factor;
	logic [30:0] implied_vol;
	logic [1:0] status;

	logic signed [31:0] pending_x[$];
	smile_pt_t smile_q[$];
	int fail_cnt = 0;
	bit no_gaps = 1'b0;
	bit sat_hit;
	wide_t lvl_a, slp_b, rho, shf_m, sig, mat_t;

	svi_smile_evaluator_core u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy), .log_moneyness(log_moneyness),
		.done(done), .total_var(total_var), .implied_var(implied_var),
		.implied_vol(implied_vol), .density_factor(density_factor), .status(status)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] abs_mag(wide_t v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic wide_t pack_mag(logic [63:0] m, bit neg, bit ovf);
		if (neg) begin
			if (ovf || m > 64'h8000_0000_0000_0000) begin
				sat_hit = 1'b1;
				return W_MIN;
			end
			return wide_t'(-m);
		end
		if (ovf || m[63]) begin
			sat_hit = 1'b1;
			return W_MAX;
		end
		return wide_t'(m);
	endfunction

	function automatic wide_t sat_add(wide_t a, wide_t b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63]) begin
			sat_hit = 1'b1;
			return s[64] ? W_MIN : W_MAX;
		end
		return s[63:0];
	endfunction

	function automatic wide_t sat_sub(wide_t a, wide_t b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s[64] != s[63]) begin
			sat_hit = 1'b1;
			return s[64] ? W_MIN : W_MAX;
		end
		return s[63:0];
	endfunction

	function automatic wide_t q_mul(wide_t a, wide_t b);
		logic [127:0] p;
		p = ({64'b0, abs_mag(a)} * {64'b0, abs_mag(b)}) >> 24;
		return pack_mag(p[63:0], (a < 0) != (b < 0), p[127:64] != 0);
	endfunction

	function automatic wide_t q_div(wide_t a, wide_t b);
		logic [127:0] quo;
		if (b == 0) begin
			sat_hit = 1'b1;
			if (a == 0)
				return 0;
			return a < 0 ? W_MIN : W_MAX;
		end
		quo = ({64'b0, abs_mag(a)} << 24) / {64'b0, abs_mag(b)};
		return pack_mag(quo[63:0], (a < 0) != (b < 0), quo[127:64] != 0);
	endfunction

	function automatic wide_t q_sqrt(wide_t v);
		logic [127:0] rad, c;
		logic [63:0] root;
		if (v <= 0)
			return 0;
		rad = {64'b0, v} << 24;
		root = '0;
		for (int i = 63; i >= 0; i--) begin
			c = {64'b0, root | (64'd1 << i)};
			if (c * c <= rad)
				root = c[63:0];
		end
		return wide_t'(root);
	endfunction

	function automatic wide_t clamp_word(wide_t v);
		if (v > 64'sh7FFF_FFFF) begin
			sat_hit = 1'b1;
			return 64'sh7FFF_FFFF;
		end
		if (v < -64'sh8000_0000) begin
			sat_hit = 1'b1;
			return -64'sh8000_0000;
		end
		return v;
	endfunction

	function automatic smile_pt_t eval_smile(logic signed [31:0] xin);
		wide_t x, d, ss, q, r, w, iv, tv_o, iv_o, vol, g, dw, d2, h, k, t, p;
		smile_pt_t e;
		sat_hit = 1'b0;
		vol = 0;
		g = 0;
		x = xin;
		d = sat_sub(x, shf_m);
		ss = q_mul(sig, sig);
		q = sat_add(q_mul(d, d), ss);
		r = q_sqrt(q);
		w = sat_add(lvl_a, q_mul(slp_b, sat_add(q_mul(rho, d), r)));
		iv = q_div(w, mat_t);
		tv_o = clamp_word(w);
		iv_o = clamp_word(iv);
		if (w > 0) begin
			vol = clamp_word(q_sqrt(iv_o));
			dw = q_mul(slp_b, sat_add(rho, q_div(d, r)));
			d2 = q_div(q_mul(slp_b, q_div(ss, q)), r);
			k = q_div(q_mul(x, dw), w);
			h = sat_sub(Q_ONE, q_mul(k, Q_HALF));
			t = sat_add(Q_QUARTER, q_div(Q_ONE, w));
			p = q_mul(q_mul(dw, dw), t);
			g = sat_add(sat_sub(q_mul(h, h), q_mul(Q_QUARTER, p)), q_mul(Q_HALF, d2));
			g = clamp_word(g);
		end
		e.tv = tv_o[31:0];
		e.iv = iv_o[31:0];
		e.vol = vol[30:0];
		e.g = g[31:0];
		e.st = (w <= 0) ? svi_pkg::STAT_NONPOS : (sat_hit ? svi_pkg::STAT_SAT : svi_pkg::STAT_OK);
		return e;
	endfunction

	always @(negedge clk) begin
		if (!(start && busy)) begin
			if (arst_n && pending_x.size() > 0 && (no_gaps || $urandom_range(99) >= 21)) begin
				start <= 1'b1;
				log_moneyness <= pending_x.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		smile_pt_t e;
		if (!arst_n) begin
			lvl_a = 0;
			slp_b = 0;
			rho = 0;
			shf_m = 0;
			sig = Q_ONE;
			mat_t = Q_ONE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					svi_pkg::REG_LEVEL_A: lvl_a = wide_t'(signed'(cfg_data));
					svi_pkg::REG_SLOPE_B: slp_b = {33'b0, cfg_data[30:0]};
					svi_pkg::REG_SKEW_RHO: rho = wide_t'(signed'(cfg_data[25:0]));
					svi_pkg::REG_SHIFT_M: shf_m = wide_t'(signed'(cfg_data));
					svi_pkg::REG_CURVATURE_SIGMA: sig = {33'b0, cfg_data[30:0]};
					svi_pkg::REG_MATURITY_YEARS: mat_t = {33'b0, cfg_data[30:0]};
					default: ;
				endcase
			end
			if (start && !busy)
				smile_q.push_back(eval_smile(log_moneyness));
			if (done) begin
				if (smile_q.size() == 0) begin
					$display("%0t: result without a pending item, total_var %h", $time,
						total_var);
					fail_cnt++;
				end else begin
					e = smile_q.pop_front();
					if (total_var !== e.tv || implied_var !== e.iv || implied_vol !== e.vol ||
							density_factor !== e.g || status !== e.st) begin
						$display("%0t: expected tv %h iv %h vol %h g %h st %0d", $time,
							e.tv, e.iv, e.vol, e.g, e.st);
						$display("%0t: actual   tv %h iv %h vol %h g %h st %0d", $time,
							total_var, implied_var, implied_vol, density_factor, status);
						fail_cnt++;
					end
				end
			end
		end
	end

	task automatic write_reg(logic [svi_pkg::IDX_BITS-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_smile(logic [31:0] a, logic [31:0] b, logic [31:0] r,
			logic [31:0] m, logic [31:0] s, logic [31:0] t);
		write_reg(svi_pkg::REG_LEVEL_A, a);
		write_reg(svi_pkg::REG_SLOPE_B, b);
		write_reg(svi_pkg::REG_SKEW_RHO, r);
		write_reg(svi_pkg::REG_SHIFT_M, m);
		write_reg(svi_pkg::REG_CURVATURE_SIGMA, s);
		write_reg(svi_pkg::REG_MATURITY_YEARS, t);
	endtask

	task automatic drain();
		do begin
			@(posedge clk);
			#0.1;
		end while (pending_x.size() > 0 || smile_q.size() > 0 || start);
	endtask

	task automatic queue_strikes(int n, logic signed [31:0] m);
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 60)
				pending_x.push_back(m + int'($urandom_range(32'h0800_0000)) - 32'sh0400_0000);
			else if (sel < 85)
				pending_x.push_back($urandom);
			else
				pending_x.push_back(int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
		end
	endtask

	function automatic logic [31:0] pick(logic [31:0] usual, logic [31:0] lo, logic [31:0] hi);
		int sel;
		sel = $urandom_range(19);
		return sel == 0 ? lo : (sel == 1 ? hi : usual);
	endfunction

	initial begin
		logic [31:0] a, b, r, m, s, t;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings give zero total variance everywhere.
		pending_x = '{0, 32'sh0100_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
		drain();

		load_smile(32'h000A_3D71, 32'h0066_6666, 32'hFF99_999A, 32'h0019_999A,
			32'h0033_3333, 32'h0080_0000);
		pending_x = '{0, 32'sh0019_999A, 32'sh0100_0000, -32'sh0100_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 1, -1, 32'sh0400_0000, -32'sh0400_0000, 32'sh0008_0000,
			32'sh5555_5555, -32'sh2AAA_AAAA, 32'sh0019_9999, 32'sh0019_999B};
		drain();

		load_smile(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0100_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h0000_0001);
		pending_x = '{0, 32'sh8000_0000, 32'sh7FFF_FFFF};
		queue_strikes(15, 32'sh8000_0000);
		drain();

		load_smile(32'h8000_0000, 32'h0000_0000, 32'h03FF_0000, 32'h7FFF_FFFF,
			32'h0000_0001, 32'h7FFF_FFFF);
		queue_strikes(15, 32'sh7FFF_FFFF);
		drain();

		// Zero sigma and maturity, rho far outside [-1,1], top bit of slope ignored.
		load_smile(32'h0000_1000, 32'hC000_0000, 32'h01FF_FFFF, 32'h0010_0000,
			32'h0000_0000, 32'h0000_0000);
		pending_x = '{32'sh0010_0000, 0};
		queue_strikes(15, 32'sh0010_0000);
		drain();

		load_smile(32'h0001_0000, 32'h0100_0000, 32'h0200_0000, 32'hFFF0_0000,
			32'h0000_0100, 32'h0100_0000);
		pending_x = '{-32'sh0010_0000};
		queue_strikes(15, -32'sh0010_0000);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			a = pick(int'($urandom_range(32'h0080_0000)) - 32'sh0020_0000, 32'h8000_0000,
				32'h7FFF_FFFF);
			b = pick($urandom_range(32'h0100_0000, 32'h0010_0000), 0, 32'h7FFF_FFFF);
			r = pick(int'($urandom_range(32'h0200_0000)) - 32'sh0100_0000, 32'hFF00_0000,
				32'h0100_0000);
			m = pick(int'($urandom_range(32'h0100_0000)) - 32'sh0080_0000, 32'h8000_0000,
				32'h7FFF_FFFF);
			s = pick($urandom_range(32'h0100_0000, 32'h0010_0000), 1, 32'h7FFF_FFFF);
			t = pick($urandom_range(32'h0400_0000, 32'h0020_0000), 1, 32'h7FFF_FFFF);
			load_smile(a, b, r, m, s, t);
			no_gaps = (ph == 4);
			queue_strikes(95, m);
			drain();
		end
		no_gaps = 1'b0;

		repeat (250) @(posedge clk);
		if (fail_cnt == 0 && smile_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/svi_pkg.sv
src/svi_fmul.sv
src/svi_fdiv.sv
src/svi_fsqrt.sv
src/svi_smile_evaluator_core.sv
src/svi_checker.sv
bench/svi_smile_evaluator_core_tb.sv
